// File: src/modbus_read_request_framer_macros.svh
// Assertion helpers used by the framer's serializer RTL.
// Each check is clocked on the rising edge and is switched off while reset is held.
`ifndef MODBUS_READ_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_READ_REQUEST_FRAMER_MACROS_SVH

`ifndef SYNTHESIS

// Antecedent implies consequent in the same cycle.
`define MRF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MRF_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define MRF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// File: src/mrf_pkg.sv
`timescale 1ns / 1ps

package mrf_pkg;

    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Byte slots of the request frame, in transmit order.
    typedef enum logic [2:0] {
        POS_ADDR     = 3'd0,
        POS_FUNC     = 3'd1,
        POS_START_HI = 3'd2,
        POS_START_LO = 3'd3,
        POS_COUNT_HI = 3'd4,
        POS_COUNT_LO = 3'd5,
        POS_CRC_LO   = 3'd6,
        POS_CRC_HI   = 3'd7
    } t_pos;

    typedef struct packed {
        logic [15:0] register_count;
        logic [15:0] start_register;
        logic [7:0]  slave_address;
    } t_req;

    // One byte through the reflected CRC-16 (eight shift steps).
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: src/mrf_serializer.sv
`timescale 1ns / 1ps

`include "modbus_read_request_framer_macros.svh"

module mrf_serializer import mrf_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_req       i_req,
    output logic       o_req_pop,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [7:0] o_frame_byte,
    output logic [2:0] o_byte_pos,
    output logic       o_last
);

    logic        r_busy, n_busy;
    t_pos        r_pos, n_pos;
    t_req        r_req, n_req;
    logic [15:0] r_crc, n_crc;

    logic        r_out_valid, n_out_valid;
    logic [7:0]  r_out_byte, n_out_byte;
    logic [2:0]  r_out_pos, n_out_pos;
    logic        r_out_last, n_out_last;

    logic        advance;
    logic        load;
    logic [7:0]  cur_byte;

    // Pick the frame byte for the current slot.
    always_comb begin
        unique case (r_pos)
            POS_ADDR:     cur_byte = r_req.slave_address;
            POS_FUNC:     cur_byte = FUNC_READ_HOLDING;
            POS_START_HI: cur_byte = r_req.start_register[15:8];
            POS_START_LO: cur_byte = r_req.start_register[7:0];
            POS_COUNT_HI: cur_byte = r_req.register_count[15:8];
            POS_COUNT_LO: cur_byte = r_req.register_count[7:0];
            POS_CRC_LO:   cur_byte = r_crc[7:0];
            POS_CRC_HI:   cur_byte = r_crc[15:8];
        endcase
    end

    assign advance   = r_busy && (!r_out_valid || i_out_ready);
    assign load      = i_req_valid && (!r_busy || (advance && (r_pos == POS_CRC_HI)));
    assign o_req_pop = load;

    always_comb begin
        n_busy      = r_busy;
        n_pos       = r_pos;
        n_req       = r_req;
        n_crc       = r_crc;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (advance) begin
            n_out_valid = 1'b1;
            n_out_byte  = cur_byte;
            n_out_pos   = r_pos;
            n_out_last  = (r_pos == POS_CRC_HI);
            n_pos       = t_pos'(r_pos + 3'd1);
            // Fold only the six body bytes into the checksum.
            if (r_pos < POS_CRC_LO) begin
                n_crc = crc_update(r_crc, cur_byte);
            end
            if (r_pos == POS_CRC_HI) begin
                n_busy = 1'b0;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end

        if (load) begin
            n_busy = 1'b1;
            n_pos  = POS_ADDR;
            n_req  = i_req;
            n_crc  = CRC_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pos       <= POS_ADDR;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_crc      <= n_crc;
        r_out_byte <= n_out_byte;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_byte;
    assign o_byte_pos   = r_out_pos;
    assign o_last       = r_out_last;

    `MRF_ASSERT_NEXT(a_pos_sequence, i_clk, i_rst_n,
        r_out_valid && i_out_ready && !r_out_last,
        !r_out_valid || (r_out_pos == ($past(r_out_pos) + 3'd1)),
        "frame byte position skipped or repeated")
    `MRF_ASSERT_SAME(a_crc_fresh, i_clk, i_rst_n,
        r_busy && (r_pos == POS_ADDR),
        r_crc == CRC_INIT,
        "checksum not seeded at frame start")
    `MRF_ASSERT_SAME(a_last_on_crc_hi, i_clk, i_rst_n,
        r_out_valid,
        r_out_last == (r_out_pos == 3'(POS_CRC_HI)),
        "last flag does not match the final byte slot")

endmodule

// File: src/modbus_read_request_framer.sv
`timescale 1ns / 1ps

// Modbus RTU read-holding-registers request framer.
// Input stream: one request per transfer, s_axis_tdata carries slave address,
// start register and register count. Output stream: the eight-byte RTU frame,
// one byte per transfer (address, 0x03, start hi/lo, count hi/lo, CRC lo/hi),
// with byte position alongside and m_axis_tlast on the CRC high byte.
// A request passes through the request buffer and then the byte engine
// before the first byte of its frame is valid. The output carries one frame
// byte per cycle while m_axis_tready stays high; the output port is the
// limit. A one-entry request buffer takes the next request while the
// current frame is still going out, so frames follow back to back. The CRC
// is accumulated one byte per cycle as the body bytes leave, except in stalls.
// Reset clears the buffer, the engine and the output valid; no clearing pass.
// When the receiver holds m_axis_tready low, the output byte holds, the
// engine stops and, once the buffer is full, s_axis_tready drops.
module modbus_read_request_framer import mrf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] slave_address, [23:8] start_register, [39:24] register_count
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte, [10:8] byte_position, [15:11] zero
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    logic       r_buf_valid, n_buf_valid;
    t_req       r_buf;
    logic       req_pop;
    logic [7:0] frame_byte;
    logic [2:0] byte_pos;

    // Take a request whenever the buffer is empty.
    assign s_axis_tready = !r_buf_valid;

    always_comb begin
        n_buf_valid = r_buf_valid;
        if (s_axis_tvalid && s_axis_tready) begin
            n_buf_valid = 1'b1;
        end else if (req_pop) begin
            n_buf_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_valid <= 1'b0;
        end else begin
            r_buf_valid <= n_buf_valid;
        end
    end

    // Hold request payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_buf <= t_req'(s_axis_tdata);
        end
    end

    mrf_serializer u_serializer (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (r_buf_valid),
        .i_req        (r_buf),
        .o_req_pop    (req_pop),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_frame_byte (frame_byte),
        .o_byte_pos   (byte_pos),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b00000, byte_pos, frame_byte};

endmodule

// File: dv/modbus_read_request_framer_tb.sv
`timescale 1ns / 1ps

// Drives directed and then random read requests into the framer, stalls the byte
// stream on its own schedule, and checks every frame byte, its position,
// the zero padding and tlast against a locally computed frame and CRC.
module modbus_read_request_framer_tb;
    import mrf_pkg::*;

    localparam int NUM_RANDOM_REQUESTS = 150;
    localparam int IDLE_LIMIT          = 2000;
    localparam int DRAIN_CYCLES        = 16;
    localparam int FRAME_BYTES         = 8;
    localparam logic [15:0] COUNT_PROTOCOL_MAX = 16'd125;

    typedef struct {
        logic [7:0] frame_byte;
        t_pos       byte_pos;
        logic       last_byte;
    } t_frame_slot;

    typedef enum {
        RX_OPEN,
        RX_RANDOM,
        RX_PERIODIC,
        RX_CHOKED
    } t_rx_mode;

    // Reflected CRC-16, one input bit at a time, LSB first.
    function automatic logic [15:0] modbus_crc(input logic [7:0] body [6]);
        logic [15:0] crc;
        logic        feedback;
        crc = CRC_INIT;
        foreach (body[n]) begin
            for (int i = 0; i < 8; i++) begin
                feedback = crc[0] ^ body[n][i];
                crc      = crc >> 1;
                if (feedback) begin
                    crc = crc ^ CRC_POLY;
                end
            end
        end
        return crc;
    endfunction

    class frame_scoreboard;
        t_frame_slot pending_bytes[$];
        int          errors;
        int          requests_seen;
        int          bytes_checked;
        int          frames_checked;
        int          zero_counts;
        int          oversize_counts;

        function new();
            errors          = 0;
            requests_seen   = 0;
            bytes_checked   = 0;
            frames_checked  = 0;
            zero_counts     = 0;
            oversize_counts = 0;
        endfunction

        // Build the whole frame for one accepted request.
        function void note_request(input t_req req);
            logic [7:0]  body [6];
            logic [15:0] crc;
            t_frame_slot slot;
            body[0] = req.slave_address;
            body[1] = FUNC_READ_HOLDING;
            body[2] = req.start_register[15:8];
            body[3] = req.start_register[7:0];
            body[4] = req.register_count[15:8];
            body[5] = req.register_count[7:0];
            crc     = modbus_crc(body);
            for (int k = 0; k < FRAME_BYTES; k++) begin
                slot.byte_pos   = t_pos'(k);
                slot.last_byte  = (slot.byte_pos == POS_CRC_HI);
                slot.frame_byte = (k < 6) ? body[k] :
                                  (slot.byte_pos == POS_CRC_LO) ? crc[7:0] : crc[15:8];
                pending_bytes.push_back(slot);
            end
            requests_seen++;
            if (req.register_count == 16'd0) begin
                zero_counts++;
            end
            if (req.register_count > COUNT_PROTOCOL_MAX) begin
                oversize_counts++;
            end
        endfunction

        function void check_byte(input logic [15:0] data, input logic last);
            t_frame_slot want;
            if (pending_bytes.size() == 0) begin
                $display("%0t ERROR: unexpected byte, expected none, got data 0x%04h last %0b",
                         $time, data, last);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (data[7:0] !== want.frame_byte) begin
                $display("%0t ERROR: frame byte at position %0d, expected 0x%02h, got 0x%02h",
                         $time, want.byte_pos, want.frame_byte, data[7:0]);
                errors++;
            end
            if (data[10:8] !== want.byte_pos) begin
                $display("%0t ERROR: byte position, expected %0d, got %0d",
                         $time, want.byte_pos, data[10:8]);
                errors++;
            end
            if (data[15:11] !== 5'd0) begin
                $display("%0t ERROR: tdata padding, expected 0x00, got 0x%02h",
                         $time, data[15:11]);
                errors++;
            end
            if (last !== want.last_byte) begin
                $display("%0t ERROR: tlast at position %0d, expected %0b, got %0b",
                         $time, want.byte_pos, want.last_byte, last);
                errors++;
            end
            bytes_checked++;
            if (want.last_byte) begin
                frames_checked++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] slave_address, [23:8] start_register, [39:24] register_count
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] frame_byte, [10:8] byte_position, [15:11] zero
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    frame_scoreboard frames;
    int              idle_cycles;

    modbus_read_request_framer u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        frames = new();
    end

    // Watch both ports: note requests first, then check bytes, then the watchdog.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                frames.note_request(t_req'(s_axis_tdata));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                frames.check_byte(m_axis_tdata, m_axis_tlast);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ERROR: no transfer for %0d cycles, %0d bytes still due",
                         $time, IDLE_LIMIT, frames.pending());
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Receiver back-pressure: switch at random between open, random, periodic and choked modes.
    t_rx_mode rx_mode;
    int       rx_mode_left;
    int       rx_low_run;
    int       rx_phase;

    initial begin
        m_axis_tready = 1'b0;
        rx_mode       = RX_OPEN;
        rx_mode_left  = 0;
        rx_low_run    = 0;
        rx_phase      = 0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(16, 80);
                rx_phase     = 0;
            end
            rx_mode_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN: begin
                    m_axis_tready = 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready = ($urandom_range(0, 9) < 7);
                end
                RX_PERIODIC: begin
                    m_axis_tready = (rx_phase % 3 != 0);
                end
                default: begin
                    // hold low most of the time, but never for long
                    m_axis_tready = ($urandom_range(0, 3) == 0) || (rx_low_run >= 8);
                end
            endcase
            rx_low_run = m_axis_tready ? 0 : rx_low_run + 1;
        end
    end

    function automatic t_req make_req(input logic [7:0] addr, input logic [15:0] start,
                                      input logic [15:0] count);
        t_req req;
        req.slave_address  = addr;
        req.start_register = start;
        req.register_count = count;
        return req;
    endfunction

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'(COUNT_PROTOCOL_MAX + $urandom_range(0, 1));
            3:       return 16'($urandom_range(1, 125));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_req();
        logic [7:0] addr;
        addr = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 8'hFF : 8'h00)
                                           : 8'($urandom);
        return make_req(addr, pick_word(), pick_word());
    endfunction

    // Present one request and hold it until taken; leaves tvalid high.
    task automatic send_request(input t_req req);
        s_axis_tdata  = req;
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // Stop sending until every frame byte has been seen.
    task automatic wait_for_drain();
        s_axis_tvalid = 1'b0;
        while (frames.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    t_req directed_reqs [$];

    initial begin
        int burst_left;
        int gap;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        idle_cycles   = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Extremes, the classic example frame, and counts on both sides of the limit.
        directed_reqs.push_back(make_req(8'h00, 16'h0000, 16'h0000));
        directed_reqs.push_back(make_req(8'hFF, 16'hFFFF, 16'hFFFF));
        directed_reqs.push_back(make_req(8'h01, 16'h0000, 16'h0001));
        directed_reqs.push_back(make_req(8'h11, 16'h006B, 16'h0003));
        directed_reqs.push_back(make_req(8'h01, 16'h0001, COUNT_PROTOCOL_MAX));
        directed_reqs.push_back(make_req(8'h01, 16'h0001, COUNT_PROTOCOL_MAX + 16'd1));
        directed_reqs.push_back(make_req(8'hF7, 16'h1234, 16'h8000));
        directed_reqs.push_back(make_req(8'hAA, 16'hAAAA, 16'h5555));
        directed_reqs.push_back(make_req(8'h55, 16'h5555, 16'hAAAA));
        directed_reqs.push_back(make_req(8'h80, 16'h8000, 16'h0080));
        directed_reqs.push_back(make_req(8'h7F, 16'h7FFF, 16'hFF00));
        foreach (directed_reqs[n]) begin
            send_request(directed_reqs[n]);
        end
        wait_for_drain();

        burst_left = 0;
        for (int n = 0; n < NUM_RANDOM_REQUESTS; n++) begin
            if (n == NUM_RANDOM_REQUESTS / 2) begin
                wait_for_drain();
            end
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                if (gap > 0) begin
                    s_axis_tvalid = 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 12);
            end
            send_request(random_req());
            burst_left--;
        end
        s_axis_tvalid = 1'b0;

        while (frames.pending() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests, %0d frames, %0d bytes checked under random stalls;",
                 frames.requests_seen, frames.frames_checked, frames.bytes_checked);
        $display("register counts of zero: %0d, above the protocol limit: %0d",
                 frames.zero_counts, frames.oversize_counts);
        if (frames.errors == 0 && frames.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
